// ===== rtl/scm_pkg.sv =====
// ----------------------------------------------------------------------------
// scm_pkg
// Shared constants, coefficient tables, types and the Q30 rounding helper
// for the sine/cosine minimax unit.
// ----------------------------------------------------------------------------
package scm_pkg;

  // Reduction works on magnitudes with 40 fraction bits
  localparam int WORK_FRAC = 40;
  // Width of the reduction remainder (below 2 * 2pi at Q40)
  localparam int RW        = 44;
  // Width of the reciprocal constant used to estimate the quotient
  localparam int KW        = 18;
  // Shift that goes with the reciprocal constant
  localparam int RECIP_SH  = 60;

  localparam logic [63:0] PI_Q60    = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] PI_W      = (PI_Q60 + (64'd1 << 19)) >> 20;
  localparam logic [63:0] HALF_PI_W = (PI_Q60 + (64'd1 << 20)) >> 21;
  localparam logic [63:0] TWO_PI_W  = (PI_Q60 + (64'd1 << 18)) >> 19;
  localparam logic [63:0] RECIP_K   = (64'd1 << RECIP_SH) / TWO_PI_W;

  typedef logic signed [32:0] scm_acc_t;

  localparam scm_acc_t ONE_Q30 = 33'sd1073741824;

  // Innermost coefficients, Q30
  localparam scm_acc_t SIN_C11 = -33'sd26;
  localparam scm_acc_t COS_C10 = -33'sd280;

  // Horner addends, one per step, outermost last
  localparam scm_acc_t SIN_COEF [5] = '{
    33'sd2956, -33'sd213040, 33'sd8947846, -33'sd178956974, 33'sd1073741824
  };
  localparam scm_acc_t COS_COEF [5] = '{
    33'sd26586, -33'sd1491253, 33'sd44739212, -33'sd536870912, 33'sd1073741824
  };

  typedef struct packed {
    logic signed [32:0] s_acc;
    logic signed [32:0] c_acc;
    logic signed [32:0] y2;
    logic signed [31:0] y;
    logic               flip;
  } scm_poly_t;

  // Shift right by 30, rounding half away from zero
  function automatic logic signed [65:0] rnd_q30(input logic signed [65:0] v);
    logic signed [65:0] bias;
    bias = 66'sd536870912 - $signed({65'd0, v[65]});
    return (v + bias) >>> 30;
  endfunction

endpackage

// ===== rtl/scm_angle_if.sv =====
// ----------------------------------------------------------------------------
// scm_angle_if
// Valid/ready channel carrying one angle beat.
// ----------------------------------------------------------------------------
interface scm_angle_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

// ===== rtl/scm_result_if.sv =====
// ----------------------------------------------------------------------------
// scm_result_if
// Valid/ready channel carrying one sine/cosine result beat.
// ----------------------------------------------------------------------------
interface scm_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sine_value;
  logic signed [31:0] cosine_value;

  modport source (output valid, output sine_value, output cosine_value, input ready);
  modport sink   (input valid, input sine_value, input cosine_value, output ready);
endinterface

// ===== rtl/scm_horner.sv =====
// ----------------------------------------------------------------------------
// scm_horner
// One registered Horner step for both polynomials: acc = acc * y^2 + coef.
// ----------------------------------------------------------------------------
module scm_horner (
  input  logic                clk_i,
  input  logic                en_i,
  input  scm_pkg::scm_acc_t   sin_coef_i,
  input  scm_pkg::scm_acc_t   cos_coef_i,
  input  scm_pkg::scm_poly_t  poly_i,
  output scm_pkg::scm_poly_t  poly_o
);
  import scm_pkg::*;

  logic signed [65:0] s_prod;
  logic signed [65:0] c_prod;
  scm_poly_t          poly_d;
  scm_poly_t          poly_q;

  always_comb begin
    s_prod = poly_i.s_acc * poly_i.y2;
    c_prod = poly_i.c_acc * poly_i.y2;
    poly_d = poly_i;
    poly_d.s_acc = 33'(rnd_q30(s_prod)) + sin_coef_i;
    poly_d.c_acc = 33'(rnd_q30(c_prod)) + cos_coef_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      poly_q <= poly_d;
    end
  end

  assign poly_o = poly_q;

endmodule

// ===== rtl/sine_cosine_minimax.sv =====
// Throughput: one angle per cycle while the result sink is ready; each of the 14 stages holds one item and
// a stage advances whenever the stage after it is empty or advancing.
// The widest work per stage is two multipliers (Horner steps); reduction stages use one.
// Reset clears the stage valid bits only; the datapath registers are not reset.
// ----------------------------------------------------------------------------
// sine_cosine_minimax
// Pipelined sine/cosine: reduce by nearest multiple of 2pi, fold to
// [-pi/2, pi/2], evaluate degree 11/10 minimax polynomials, round and clamp.
// ----------------------------------------------------------------------------
module sine_cosine_minimax #(
  parameter int ANGLE_FRAC_BITS  = 24,
  parameter int RESULT_FRAC_BITS = 30
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  scm_angle_if.sink      angle_i,
  scm_result_if.source   result_o
);
  import scm_pkg::*;

  localparam int NST     = 14;
  localparam int SHIFT_W = WORK_FRAC - ANGLE_FRAC_BITS;
  localparam int MXW     = 32 + SHIFT_W;
  localparam int QW      = MXW - 42;
  localparam int QLSB    = RECIP_SH - SHIFT_W;
  localparam int SH      = 30 - RESULT_FRAC_BITS;

  localparam logic [KW-1:0]        RK      = RECIP_K[KW-1:0];
  localparam logic [42:0]          TWO_PI  = TWO_PI_W[42:0];
  localparam logic [RW-1:0]        TWO_PI_R = RW'(TWO_PI_W);
  localparam logic signed [RW-1:0] PI_S    = RW'(PI_W);
  localparam logic signed [RW-1:0] HPI_S   = RW'(HALF_PI_W);
  localparam logic [33:0]          FHALF   = (34'd1 << SH) >> 1;
  localparam scm_acc_t             LIM     = 33'sd1 <<< RESULT_FRAC_BITS;

  // Stage valid bits and per-stage advance enables
  logic [NST-1:0] vld_q;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld_q[NST-1] || result_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign angle_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= angle_i.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 0: magnitude and sign
  logic [31:0] mag0_q;
  logic        neg0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      neg0_q <= angle_i.angle[31];
      mag0_q <= angle_i.angle[31] ? (~angle_i.angle + 32'd1) : angle_i.angle;
    end
  end

  // Stage 1: quotient estimate by reciprocal, floor or one below
  logic [31+KW:0] qprod;
  logic [QW-1:0]  q1_q;
  logic [31:0]    mag1_q;
  logic           neg1_q;

  assign qprod = mag0_q * RK;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      q1_q   <= qprod[QLSB +: QW];
      mag1_q <= mag0_q;
      neg1_q <= neg0_q;
    end
  end

  // Stage 2: remainder against the estimate, lies in [0, 2 * 2pi)
  logic [MXW-1:0] mx;
  logic [MXW-1:0] qt;
  logic [MXW-1:0] rdiff;
  logic [RW-1:0]  r2_q;
  logic           neg2_q;

  assign mx    = {mag1_q, {SHIFT_W{1'b0}}};
  assign qt    = MXW'(q1_q) * MXW'(TWO_PI);
  assign rdiff = mx - qt;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      r2_q   <= rdiff[RW-1:0];
      neg2_q <= neg1_q;
    end
  end

  // Stage 3: finish floor, then round to nearest with halves going up
  logic [RW-1:0]        r1;
  logic                 rnd_up;
  logic signed [RW-1:0] r3_d;
  logic signed [RW-1:0] r3_q;
  logic                 neg3_q;

  always_comb begin
    r1     = (r2_q >= TWO_PI_R) ? (r2_q - TWO_PI_R) : r2_q;
    rnd_up = {r1, 1'b0} >= {1'b0, TWO_PI_R};
    r3_d   = rnd_up ? ($signed(r1) - $signed(TWO_PI_R)) : $signed(r1);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      r3_q   <= r3_d;
      neg3_q <= neg2_q;
    end
  end

  // Stage 4: apply sign, fold into [-pi/2, pi/2]
  logic signed [RW-1:0] rs;
  logic signed [RW-1:0] yf_d;
  logic                 flip_d;
  logic signed [RW-1:0] yf4_q;
  logic                 flip4_q;

  always_comb begin
    rs     = neg3_q ? -r3_q : r3_q;
    yf_d   = rs;
    flip_d = 1'b0;
    if (rs > HPI_S) begin
      yf_d   = PI_S - rs;
      flip_d = 1'b1;
    end else if (rs < -HPI_S) begin
      yf_d   = -PI_S - rs;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      yf4_q   <= yf_d;
      flip4_q <= flip_d;
    end
  end

  // Stage 5: round Q40 to Q30
  logic signed [RW-1:0] yb;
  logic signed [RW-1:0] ysh;
  logic signed [31:0]   y5_q;
  logic                 flip5_q;

  assign yb  = RW'(512) - $signed({{(RW-1){1'b0}}, yf4_q[RW-1]});
  assign ysh = (yf4_q + yb) >>> (WORK_FRAC - 30);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      y5_q    <= ysh[31:0];
      flip5_q <= flip4_q;
    end
  end

  // Stage 6: y squared, seed both accumulators
  logic signed [65:0] yy;
  scm_poly_t          poly0_q;
  scm_poly_t          poly [6];

  assign yy = y5_q * y5_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      poly0_q.y2    <= 33'(rnd_q30(yy));
      poly0_q.y     <= y5_q;
      poly0_q.flip  <= flip5_q;
      poly0_q.s_acc <= SIN_C11;
      poly0_q.c_acc <= COS_C10;
    end
  end

  assign poly[0] = poly0_q;

  // Stages 7 to 11: Horner steps
  for (genvar j = 0; j < 5; j++) begin : g_horner
    scm_horner u_step (
      .clk_i      (clk_i),
      .en_i       (en[7+j]),
      .sin_coef_i (SIN_COEF[j]),
      .cos_coef_i (COS_COEF[j]),
      .poly_i     (poly[j]),
      .poly_o     (poly[j+1])
    );
  end

  // Stage 12: final multiply by y for sine, sign flip for cosine
  logic signed [65:0] sy;
  scm_acc_t           s12_q;
  scm_acc_t           c12_q;

  assign sy = poly[5].s_acc * poly[5].y;

  always_ff @(posedge clk_i) begin
    if (en[12]) begin
      s12_q <= 33'(rnd_q30(sy));
      c12_q <= poly[5].flip ? -poly[5].c_acc : poly[5].c_acc;
    end
  end

  // Stage 13: round to the result format, clamp, hold for the sink
  function automatic scm_acc_t finish(input scm_acc_t v);
    logic signed [33:0] bias;
    logic signed [33:0] sh;
    scm_acc_t           r;
    bias = $signed(FHALF) - $signed({33'd0, v[32] && (SH != 0)});
    sh   = (34'(v) + bias) >>> SH;
    r    = sh[32:0];
    if (r > LIM) begin
      r = LIM;
    end else if (r < -LIM) begin
      r = -LIM;
    end
    return r;
  endfunction

  scm_acc_t           s_fin;
  scm_acc_t           c_fin;
  logic signed [31:0] sine_q;
  logic signed [31:0] cosine_q;

  assign s_fin = finish(s12_q);
  assign c_fin = finish(c12_q);

  always_ff @(posedge clk_i) begin
    if (en[13]) begin
      sine_q   <= s_fin[31:0];
      cosine_q <= c_fin[31:0];
    end
  end

  assign result_o.valid        = vld_q[NST-1];
  assign result_o.sine_value   = sine_q;
  assign result_o.cosine_value = cosine_q;

endmodule
